### rtl/core/rct_pkg.sv
// Shared types, codes and the microcode program of the reference count table.
// Used by all modules under rtl/core but rct_ram; depends on nothing else.
package rct_pkg;

  localparam int ADDR_W     = 32;
  localparam int SLOT_IDX_W = 4;
  localparam int UPC_W      = 4;

  typedef logic [UPC_W-1:0] upc_t;
  typedef logic [3:0]       op_t;
  typedef logic [3:0]       jmp_t;

  // Datapath operations.
  localparam op_t OP_NONE     = 4'd0;
  localparam op_t OP_KEY_ZERO = 4'd1;
  localparam op_t OP_KEY_OLD  = 4'd2;
  localparam op_t OP_KEY_NEW  = 4'd3;
  localparam op_t OP_ALLOC_WR = 4'd4;
  localparam op_t OP_FULL     = 4'd5;
  localparam op_t OP_NF       = 4'd6;
  localparam op_t OP_DEC      = 4'd7;
  localparam op_t OP_INC      = 4'd8;

  // Next-step conditions.
  localparam jmp_t J_NONE     = 4'd0;
  localparam jmp_t J_ALWAYS   = 4'd1;
  localparam jmp_t J_WAIT_IN  = 4'd2;
  localparam jmp_t J_SCAN     = 4'd3;
  localparam jmp_t J_KIND     = 4'd4;
  localparam jmp_t J_BLK_NULL = 4'd5;
  localparam jmp_t J_OLD_NULL = 4'd6;
  localparam jmp_t J_NEW_NULL = 4'd7;
  localparam jmp_t J_WAIT_OUT = 4'd8;

  // Program steps.
  localparam upc_t ST_IDLE   = 4'd0;
  localparam upc_t ST_DISP   = 4'd1;
  localparam upc_t ST_ANULL  = 4'd2;
  localparam upc_t ST_ASCAN  = 4'd3;
  localparam upc_t ST_AFULL  = 4'd4;
  localparam upc_t ST_AWR    = 4'd5;
  localparam upc_t ST_ONULL  = 4'd6;
  localparam upc_t ST_OSCAN  = 4'd7;
  localparam upc_t ST_OMISS  = 4'd8;
  localparam upc_t ST_ODEC   = 4'd9;
  localparam upc_t ST_NNULL  = 4'd10;
  localparam upc_t ST_NSCAN  = 4'd11;
  localparam upc_t ST_NMISS  = 4'd12;
  localparam upc_t ST_NINC   = 4'd13;
  localparam upc_t ST_FINISH = 4'd14;

  typedef struct packed {
    op_t  op;
    jmp_t jmp;
    upc_t target;
  } ctrl_t;

  // Datapath flags seen by the sequencer.
  typedef struct packed {
    logic hit;
    logic last;
    logic kind;
    logic blk_null;
    logic old_null;
    logic new_null;
  } stat_t;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  table_full;
    logic                  free_request;
    logic [ADDR_W-1:0]     freed_address;
    logic                  not_found;
    logic                  count_saturated;
  } res_t;

  // Control store: one control word per step.
  function automatic ctrl_t ucode(input upc_t step);
    ctrl_t cw;
    cw = '{op: OP_NONE, jmp: J_ALWAYS, target: ST_IDLE};
    case (step)
      ST_IDLE:   cw = '{op: OP_NONE,     jmp: J_WAIT_IN,  target: ST_IDLE};
      ST_DISP:   cw = '{op: OP_NONE,     jmp: J_KIND,     target: ST_ONULL};
      ST_ANULL:  cw = '{op: OP_KEY_ZERO, jmp: J_BLK_NULL, target: ST_FINISH};
      ST_ASCAN:  cw = '{op: OP_NONE,     jmp: J_SCAN,     target: ST_AWR};
      ST_AFULL:  cw = '{op: OP_FULL,     jmp: J_ALWAYS,   target: ST_FINISH};
      ST_AWR:    cw = '{op: OP_ALLOC_WR, jmp: J_ALWAYS,   target: ST_FINISH};
      ST_ONULL:  cw = '{op: OP_KEY_OLD,  jmp: J_OLD_NULL, target: ST_NNULL};
      ST_OSCAN:  cw = '{op: OP_NONE,     jmp: J_SCAN,     target: ST_ODEC};
      ST_OMISS:  cw = '{op: OP_NF,       jmp: J_ALWAYS,   target: ST_NNULL};
      ST_ODEC:   cw = '{op: OP_DEC,      jmp: J_NONE,     target: ST_IDLE};
      ST_NNULL:  cw = '{op: OP_KEY_NEW,  jmp: J_NEW_NULL, target: ST_FINISH};
      ST_NSCAN:  cw = '{op: OP_NONE,     jmp: J_SCAN,     target: ST_NINC};
      ST_NMISS:  cw = '{op: OP_NF,       jmp: J_ALWAYS,   target: ST_FINISH};
      ST_NINC:   cw = '{op: OP_INC,      jmp: J_NONE,     target: ST_IDLE};
      ST_FINISH: cw = '{op: OP_NONE,     jmp: J_WAIT_OUT, target: ST_IDLE};
      default:   cw = '{op: OP_NONE,     jmp: J_ALWAYS,   target: ST_IDLE};
    endcase
    return cw;
  endfunction

endpackage

### rtl/core/rct_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module rct_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/rct_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on rct_pkg for the control word, codes and program.
module rct_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_free,
  input  rct_pkg::stat_t stat,
  output rct_pkg::ctrl_t ctrl,
  output logic           in_ready,
  output logic           out_load
);
  import rct_pkg::*;

  upc_t  upc_r, upc_nxt;
  ctrl_t cw;

  assign cw       = ucode(upc_r);
  assign ctrl     = cw;
  assign in_ready = (upc_r == ST_IDLE);
  assign out_load = (cw.jmp == J_WAIT_OUT) && out_free;

  // Next step: jump target, hold in place, or fall through.
  always_comb begin
    upc_nxt = upc_r + upc_t'(1);
    case (cw.jmp)
      J_NONE:     upc_nxt = upc_r + upc_t'(1);
      J_ALWAYS:   upc_nxt = cw.target;
      J_WAIT_IN:  upc_nxt = in_valid ? upc_r + upc_t'(1) : upc_r;
      J_SCAN: begin
        if (stat.hit) begin
          upc_nxt = cw.target;
        end else if (stat.last) begin
          upc_nxt = upc_r + upc_t'(1);
        end else begin
          upc_nxt = upc_r;
        end
      end
      J_KIND:     upc_nxt = stat.kind ? cw.target : upc_r + upc_t'(1);
      J_BLK_NULL: upc_nxt = stat.blk_null ? cw.target : upc_r + upc_t'(1);
      J_OLD_NULL: upc_nxt = stat.old_null ? cw.target : upc_r + upc_t'(1);
      J_NEW_NULL: upc_nxt = stat.new_null ? cw.target : upc_r + upc_t'(1);
      J_WAIT_OUT: upc_nxt = out_free ? cw.target : upc_r;
      default:    upc_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (upc_r == ST_DISP))
    else $error("accepted word did not move to dispatch");
  a_load_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (upc_r == ST_IDLE))
    else $error("result load did not return to idle");
`endif

endmodule

### rtl/core/rct_datapath.sv
// Datapath: latched input word, slot table in RAM with valid bits, scan
// pipeline, count update and result registers. Depends on rct_pkg, rct_ram.
module rct_datapath #(
  parameter int SLOTS       = 16,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_accept,
  input  logic                       in_kind,
  input  logic [rct_pkg::ADDR_W-1:0] in_block_address,
  input  logic [rct_pkg::ADDR_W-1:0] in_old_address,
  input  logic [rct_pkg::ADDR_W-1:0] in_new_address,
  input  rct_pkg::ctrl_t             ctrl,
  output rct_pkg::stat_t             stat,
  output rct_pkg::res_t              res
);
  import rct_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int ENT_W = ADDR_W + COUNT_WIDTH;
  localparam logic [IDX_W-1:0]       LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

  logic                   kind_r;
  logic [ADDR_W-1:0]      blk_r, old_r, new_r, key_r;
  logic [IDX_W-1:0]       scan_idx_r, chk_idx_r, hit_idx_r;
  logic                   pend_r, ent_vld_r;
  logic [SLOTS-1:0]       vld_r;
  logic [COUNT_WIDTH-1:0] hit_cnt_r;
  res_t                   res_r, res_nxt;

  logic                   we;
  logic [ENT_W-1:0]       wdata, rdata;
  logic [ADDR_W-1:0]      eff_addr;
  logic [COUNT_WIDTH-1:0] eff_cnt, cnt_dec;
  logic                   scanning, hit, start_scan;

  rct_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (hit_idx_r),
    .wdata (wdata),
    .raddr (scan_idx_r),
    .rdata (rdata)
  );

  // An entry never written reads as an empty slot with count zero.
  assign eff_addr = ent_vld_r ? rdata[ENT_W-1 -: ADDR_W] : '0;
  assign eff_cnt  = ent_vld_r ? rdata[COUNT_WIDTH-1:0] : '0;

  assign scanning   = (ctrl.jmp == J_SCAN);
  assign hit        = scanning && pend_r && (eff_addr == key_r);
  assign start_scan = (ctrl.op == OP_KEY_ZERO) || (ctrl.op == OP_KEY_OLD) ||
                      (ctrl.op == OP_KEY_NEW);
  assign cnt_dec    = (hit_cnt_r == '0) ? '0 : hit_cnt_r - CNT_ONE;

  assign stat.hit      = hit;
  assign stat.last     = pend_r && (chk_idx_r == LAST_IDX);
  assign stat.kind     = kind_r;
  assign stat.blk_null = (blk_r == '0);
  assign stat.old_null = (old_r == '0);
  assign stat.new_null = (new_r == '0);
  assign res           = res_r;

  // Table writes and result flags for the current step.
  always_comb begin
    we      = 1'b0;
    wdata   = {key_r, hit_cnt_r};
    res_nxt = res_r;
    case (ctrl.op)
      OP_ALLOC_WR: begin
        we                 = 1'b1;
        wdata              = {blk_r, CNT_ONE};
        res_nxt.slot_index = SLOT_IDX_W'(hit_idx_r);
      end
      OP_FULL: res_nxt.table_full = 1'b1;
      OP_NF:   res_nxt.not_found  = 1'b1;
      OP_DEC: begin
        we                 = 1'b1;
        res_nxt.slot_index = SLOT_IDX_W'(hit_idx_r);
        if (cnt_dec == '0) begin
          wdata                 = '0;
          res_nxt.free_request  = 1'b1;
          res_nxt.freed_address = key_r;
        end else begin
          wdata = {key_r, cnt_dec};
        end
      end
      OP_INC: begin
        if (hit_cnt_r == CNT_MAX) begin
          res_nxt.count_saturated = 1'b1;
        end else begin
          we    = 1'b1;
          wdata = {key_r, hit_cnt_r + CNT_ONE};
        end
      end
      default: ;
    endcase
  end

  // Input word capture; payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r <= in_kind;
      blk_r  <= in_block_address;
      old_r  <= in_old_address;
      new_r  <= in_new_address;
    end
  end

  // Search key and hit capture.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_KEY_ZERO: key_r <= '0;
      OP_KEY_OLD:  key_r <= old_r;
      OP_KEY_NEW:  key_r <= new_r;
      default: ;
    endcase
    ent_vld_r <= vld_r[scan_idx_r];
    if (scanning) begin
      chk_idx_r <= scan_idx_r;
    end
    if (hit) begin
      hit_idx_r <= chk_idx_r;
      hit_cnt_r <= eff_cnt;
    end
  end

  // Scan pointer, pipeline flag, valid bits and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      pend_r     <= 1'b0;
      vld_r      <= '0;
      res_r      <= '0;
    end else begin
      if (start_scan) begin
        scan_idx_r <= '0;
        pend_r     <= 1'b0;
      end else if (scanning) begin
        pend_r <= 1'b1;
        if (scan_idx_r != LAST_IDX) begin
          scan_idx_r <= scan_idx_r + IDX_W'(1);
        end
      end
      if (we) begin
        vld_r[hit_idx_r] <= 1'b1;
      end
      if (in_accept) begin
        res_r <= '0;
      end else begin
        res_r <= res_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.table_full |-> (res_r.slot_index == '0) && !res_r.free_request)
    else $error("full allocate reported a slot or a free");
  a_freed_nonnull: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.free_request |-> (res_r.freed_address != '0))
    else $error("free request carries a null address");
`endif

endmodule

### rtl/core/reference_count_table_top.sv
// Top level of the reference count table: sequencer, datapath, result register.
// Depends on rct_pkg, rct_seq, rct_datapath and rct_ram.
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  input   | in_valid/in_ready, kind, block/old/new address     | in
//  result  | out_valid/out_ready, slot, flags, freed_address    | out
//
// How long an allocate word takes depends on the slot it lands in or on the table
// being full, and a reassign word on where its addresses sit. Both are set by
// the slot scan, which reads one table entry per cycle from the single RAM read
// port, once for the old and once for the new address of a reassign word.
// Synchronous reset empties the table at once through per-slot valid bits.
// A new word is taken while a result waits for out_ready; it then holds in its
// last step until the output register is free.
module reference_count_table_top #(
  parameter int SLOTS       = 16,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic [rct_pkg::ADDR_W-1:0] in_block_address,
  input  logic [rct_pkg::ADDR_W-1:0] in_old_address,
  input  logic [rct_pkg::ADDR_W-1:0] in_new_address,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rct_pkg::SLOT_IDX_W-1:0] out_slot_index,
  output logic                       out_table_full,
  output logic                       out_free_request,
  output logic [rct_pkg::ADDR_W-1:0] out_freed_address,
  output logic                       out_not_found,
  output logic                       out_count_saturated
);
  import rct_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  res_t  res, out_r;
  logic  out_valid_r, out_free, out_load, in_accept;

  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  rct_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_ready (in_ready),
    .out_load (out_load)
  );

  rct_datapath #(.SLOTS(SLOTS), .COUNT_WIDTH(COUNT_WIDTH)) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_accept        (in_accept),
    .in_kind          (in_kind),
    .in_block_address (in_block_address),
    .in_old_address   (in_old_address),
    .in_new_address   (in_new_address),
    .ctrl             (ctrl),
    .stat             (stat),
    .res              (res)
  );

  // Output register holds the finished word until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_slot_index      = out_r.slot_index;
  assign out_table_full      = out_r.table_full;
  assign out_free_request    = out_r.free_request;
  assign out_freed_address   = out_r.freed_address;
  assign out_not_found       = out_r.not_found;
  assign out_count_saturated = out_r.count_saturated;

endmodule

### dv/reference_count_table_top_tb.sv
`timescale 1ns / 1ps
// Testbench for reference_count_table_top: drives allocate and reassign words and
// checks every result against a local copy of the slot table kept in the bench.
// Depends on rct_pkg and the reference_count_table_top RTL.
module reference_count_table_top_tb;
  import rct_pkg::*;

  localparam int SLOTS       = 16;
  localparam int COUNT_WIDTH = 8;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

  localparam logic KIND_ALLOC    = 1'b0;
  localparam logic KIND_REASSIGN = 1'b1;
  localparam logic [ADDR_W-1:0] NULL_ADDR = '0;
  localparam logic [ADDR_W-1:0] ALL_ONES  = '1;

  localparam int POOL_SIZE     = 12;
  localparam int RANDOM_WORDS  = 2000;
  localparam int SEGMENT_WORDS = 250;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 64;
  localparam int STALL_LIMIT   = 4000;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic                    clk                 = 1'b0;
  logic                    rst_n               = 1'b0;
  logic                    in_valid            = 1'b0;
  logic                    in_ready;
  logic                    in_kind             = KIND_ALLOC;
  logic [ADDR_W-1:0]       in_block_address    = '0;
  logic [ADDR_W-1:0]       in_old_address      = '0;
  logic [ADDR_W-1:0]       in_new_address      = '0;
  logic                    out_valid;
  logic                    out_ready           = 1'b0;
  logic [SLOT_IDX_W-1:0]   out_slot_index;
  logic                    out_table_full;
  logic                    out_free_request;
  logic [ADDR_W-1:0]       out_freed_address;
  logic                    out_not_found;
  logic                    out_count_saturated;

  // Local copy of the slot table and the results still owed by the block.
  logic [ADDR_W-1:0]      tbl_addr  [SLOTS];
  logic [COUNT_WIDTH-1:0] tbl_count [SLOTS];
  res_t                   pending_results[$];
  logic [ADDR_W-1:0]      addr_pool [POOL_SIZE];
  int                     err_count = 0;

  // Sender pacing and receiver behavior, set by the test tasks.
  int       burst_left     = 0;
  int       sender_gap_max = 0;
  rx_mode_e rx_mode        = RX_ALWAYS;
  int       rx_hold_len    = 0;
  int       rx_hold_left   = 0;
  int       rx_phase       = 0;
  int       quiet_cycles   = 0;

  always #4 clk = ~clk;

  reference_count_table_top #(
    .SLOTS       (SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_block_address    (in_block_address),
    .in_old_address      (in_old_address),
    .in_new_address      (in_new_address),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_slot_index      (out_slot_index),
    .out_table_full      (out_table_full),
    .out_free_request    (out_free_request),
    .out_freed_address   (out_freed_address),
    .out_not_found       (out_not_found),
    .out_count_saturated (out_count_saturated)
  );

  // Lowest slot holding addr, or -1 when no slot holds it.
  function automatic int lowest_slot(input logic [ADDR_W-1:0] addr);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  // Applies one word to the local table and returns the result it must produce.
  // A slot in use never holds a zero count, so the hold-at-zero guard on the
  // decrement is not reached from the ports.
  function automatic res_t apply_table_word(input logic kind,
                                            input logic [ADDR_W-1:0] blk, old_addr,
                                                                     new_addr);
    res_t r;
    int   s;
    r = '0;
    if (kind == KIND_ALLOC) begin
      if (blk != NULL_ADDR) begin
        s = lowest_slot(NULL_ADDR);
        if (s < 0) begin
          r.table_full = 1'b1;
        end else begin
          tbl_addr[s]  = blk;
          tbl_count[s] = COUNT_ONE;
          r.slot_index = s[SLOT_IDX_W-1:0];
        end
      end
    end else begin
      // The decrement and any clearing come before the search for new_addr.
      if (old_addr != NULL_ADDR) begin
        s = lowest_slot(old_addr);
        if (s < 0) begin
          r.not_found = 1'b1;
        end else begin
          r.slot_index = s[SLOT_IDX_W-1:0];
          if (tbl_count[s] != '0) tbl_count[s] = tbl_count[s] - COUNT_ONE;
          if (tbl_count[s] == '0) begin
            r.free_request  = 1'b1;
            r.freed_address = tbl_addr[s];
            tbl_addr[s]     = NULL_ADDR;
          end
        end
      end
      if (new_addr != NULL_ADDR) begin
        s = lowest_slot(new_addr);
        if (s < 0) begin
          r.not_found = 1'b1;
        end else if (tbl_count[s] == COUNT_MAX) begin
          r.count_saturated = 1'b1;
        end else begin
          tbl_count[s] = tbl_count[s] + COUNT_ONE;
        end
      end
    end
    return r;
  endfunction

  // Bursts of random length separated by random gaps; no gap when the max is zero.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 16);
    gap = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offers one word, waits for it to be taken and records the result it owes.
  task automatic send_word(input logic kind,
                           input logic [ADDR_W-1:0] blk, old_addr, new_addr);
    pace_sender();
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_block_address <= blk;
    in_old_address   <= old_addr;
    in_new_address   <= new_addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_table_word(kind, blk, old_addr, new_addr));
  endtask

  // Address held by some slot in use, or null when the table is empty.
  function automatic logic [ADDR_W-1:0] pick_held();
    int start;
    start = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_addr[(start + i) % SLOTS] != NULL_ADDR) return tbl_addr[(start + i) % SLOTS];
    end
    return NULL_ADDR;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_any();
    case ($urandom_range(0, 3))
      0:       return NULL_ADDR;
      1:       return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      2:       return pick_held();
      default: return $urandom();
    endcase
  endfunction

  // Null allocate, duplicates, null and missing addresses, and old equal to new.
  task automatic test_directed_ops();
    sender_gap_max = 3;
    rx_mode        = RX_RANDOM;
    send_word(KIND_ALLOC, NULL_ADDR, ALL_ONES, ALL_ONES);
    send_word(KIND_ALLOC, ALL_ONES, NULL_ADDR, NULL_ADDR);
    send_word(KIND_ALLOC, 32'h0000_0001, ALL_ONES, ALL_ONES);
    send_word(KIND_ALLOC, ALL_ONES, NULL_ADDR, NULL_ADDR);
    send_word(KIND_REASSIGN, ALL_ONES, NULL_ADDR, 32'h0000_0001);
    // The first two frees of the duplicated address hit the lower slot first.
    send_word(KIND_REASSIGN, NULL_ADDR, ALL_ONES, NULL_ADDR);
    send_word(KIND_REASSIGN, NULL_ADDR, ALL_ONES, NULL_ADDR);
    send_word(KIND_REASSIGN, NULL_ADDR, 32'hDEAD_BEEF, 32'h0000_0001);
    send_word(KIND_REASSIGN, NULL_ADDR, 32'h0000_0001, 32'h5555_AAAA);
    send_word(KIND_REASSIGN, NULL_ADDR, 32'h0000_0001, 32'h0000_0001);
    send_word(KIND_REASSIGN, NULL_ADDR, 32'h0000_0001, NULL_ADDR);
    // Old equal to new at count one: freed first, so the new address is missing.
    send_word(KIND_REASSIGN, NULL_ADDR, 32'h0000_0001, 32'h0000_0001);
    send_word(KIND_REASSIGN, NULL_ADDR, NULL_ADDR, NULL_ADDR);
    send_word(KIND_REASSIGN, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
  endtask

  // Drives one count up to its maximum and past it, then back down a step.
  task automatic test_count_saturation();
    logic [ADDR_W-1:0] hot;
    hot            = 32'h1234_5678;
    sender_gap_max = 0;
    rx_mode        = RX_ALWAYS;
    send_word(KIND_ALLOC, hot, $urandom(), $urandom());
    for (int i = 0; i < int'(COUNT_MAX) + 2; i++) begin
      send_word(KIND_REASSIGN, $urandom(), NULL_ADDR, hot);
    end
    send_word(KIND_REASSIGN, NULL_ADDR, hot, hot);
    send_word(KIND_REASSIGN, NULL_ADDR, hot, NULL_ADDR);
  endtask

  // Fills every empty slot, overflows the table, then frees every other slot.
  task automatic test_table_full();
    sender_gap_max = 5;
    rx_mode        = RX_PERIODIC;
    while (lowest_slot(NULL_ADDR) >= 0) begin
      send_word(KIND_ALLOC, $urandom() | 32'h1, $urandom(), $urandom());
    end
    send_word(KIND_ALLOC, ALL_ONES, NULL_ADDR, NULL_ADDR);
    send_word(KIND_ALLOC, 32'h0000_0002, NULL_ADDR, NULL_ADDR);
    for (int i = 1; i < SLOTS; i += 2) begin
      send_word(KIND_REASSIGN, NULL_ADDR, tbl_addr[i], NULL_ADDR);
    end
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the
  // result register fills and the input side has to stall.
  task automatic test_input_stall();
    sender_gap_max = 0;
    rx_mode        = RX_ALWAYS;
    rx_hold_len    = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 0) send_word(KIND_ALLOC, $urandom(), NULL_ADDR, NULL_ADDR);
      else send_word(KIND_REASSIGN, $urandom(), pick_held(), pick_held());
    end
  endtask

  // Mostly well-formed traffic on addresses the table holds, plus noise.
  task automatic test_random_traffic();
    int                roll;
    int                sel;
    logic [ADDR_W-1:0] blk;
    logic [ADDR_W-1:0] old_addr;
    logic [ADDR_W-1:0] new_addr;
    addr_pool[0] = ALL_ONES;
    addr_pool[1] = 32'h0000_0001;
    addr_pool[2] = 32'h8000_0000;
    addr_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) addr_pool[i] = $urandom() | 32'h1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // New pacing for each segment; the first one runs with no idling at all.
      if (n % SEGMENT_WORDS == 0) begin
        if (n == 0) begin
          sender_gap_max = 0;
          rx_mode        = RX_ALWAYS;
        end else begin
          case ($urandom_range(0, 2))
            0:       sender_gap_max = 0;
            1:       sender_gap_max = 3;
            default: sender_gap_max = 30;
          endcase
          rx_mode = rx_mode_e'($urandom_range(0, 2));
        end
      end
      roll     = $urandom_range(0, 99);
      blk      = $urandom();
      old_addr = $urandom();
      new_addr = $urandom();
      if (roll < 35) begin
        if (roll < 2) blk = NULL_ADDR;
        else if (roll < 20) blk = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        send_word(KIND_ALLOC, blk, old_addr, new_addr);
      end else if (roll < 85) begin
        sel      = $urandom_range(0, 9);
        old_addr = pick_held();
        if (sel < 3) new_addr = NULL_ADDR;
        else if (sel < 8) new_addr = pick_held();
        else new_addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        send_word(KIND_REASSIGN, blk, old_addr, new_addr);
      end else begin
        send_word(KIND_REASSIGN, blk, pick_any(), pick_any());
      end
    end
  endtask

  // Receiver: a long hold-off when one is asked for, else the current pattern.
  always @(posedge clk) begin
    if (rx_hold_len != 0) begin
      rx_hold_left = rx_hold_len;
      rx_hold_len  = 0;
    end
    rx_phase = (rx_phase + 1) % 11;
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        default:   out_ready <= (rx_phase >= 4);
      endcase
    end
  end

  function automatic void check_field(input string fname,
                                      input logic [ADDR_W-1:0] want, got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
      err_count++;
    end
  endfunction

  // Each result word taken is compared with the oldest outstanding prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing outstanding: slot_index 0x%0h", out_slot_index);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("slot_index", ADDR_W'(want.slot_index), ADDR_W'(out_slot_index));
        check_field("table_full", ADDR_W'(want.table_full), ADDR_W'(out_table_full));
        check_field("free_request", ADDR_W'(want.free_request),
                    ADDR_W'(out_free_request));
        check_field("freed_address", want.freed_address, out_freed_address);
        check_field("not_found", ADDR_W'(want.not_found), ADDR_W'(out_not_found));
        check_field("count_saturated", ADDR_W'(want.count_saturated),
                    ADDR_W'(out_count_saturated));
      end
    end
  end

  // Watchdog: too many cycles in a row with no word taken on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_addr[i]  = NULL_ADDR;
      tbl_count[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_count_saturation();
    test_table_full();
    test_input_stall();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### reference_count_table_top.f
rtl/core/rct_pkg.sv
rtl/core/rct_ram.sv
rtl/core/rct_seq.sv
rtl/core/rct_datapath.sv
rtl/core/reference_count_table_top.sv
dv/reference_count_table_top_tb.sv
